/* rtl/stbs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared constants, payload types and state codes of the sorted table search.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = 10;
    localparam int VAL_W      = 32;
    localparam int POS_W      = 11;
    localparam int CFG_CNT_W  = 11;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // request codes
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // register indexes
    localparam logic REG_ENTRY_COUNT  = 1'b0;
    localparam logic REG_SIGNED_ORDER = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] entry_index;
        logic [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_rsp;

    typedef struct packed {
        logic [CFG_CNT_W-1:0] entry_count;
        logic                 signed_order;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef enum logic {
        ST_IDLE,
        ST_CHECK
    } t_state;

    // flipping the sign bit maps two's complement order onto unsigned order
    function automatic logic [DATA_W-1:0] order_key(input logic [DATA_W-1:0] v,
                                                    input logic              sgn);
        order_key = v ^ {sgn, {(DATA_W-1){1'b0}}};
    endfunction

endpackage
`default_nettype wire

/* rtl/stbs_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds when no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/stbs_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_regs
// APB register block: entry count and signed order select.
// ----------------------------------------------------------------------------
module stbs_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [stbs_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [stbs_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [stbs_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output stbs_pkg::t_cfg                      o_cfg
);
    import stbs_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_en;
    logic reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_sel)
                REG_ENTRY_COUNT:  n_cfg.entry_count  = pwdata[CFG_CNT_W-1:0];
                REG_SIGNED_ORDER: n_cfg.signed_order = pwdata[0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_ENTRY_COUNT:  prdata = APB_DATA_W'(r_cfg.entry_count);
            REG_SIGNED_ORDER: prdata = APB_DATA_W'(r_cfg.signed_order);
            default:          prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule
`default_nettype wire

/* rtl/stbs_search.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_search
// Request handling and probe sequencer: one table read per cycle, compare on
// the returned word, narrow the range and issue the next read.
// ----------------------------------------------------------------------------
module stbs_search (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire stbs_pkg::t_cfg             i_cfg,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire stbs_pkg::t_req             i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output stbs_pkg::t_rsp                  o_out_data,
    output stbs_pkg::t_ram_req              o_ram,
    input  wire logic [stbs_pkg::DATA_W-1:0] i_rdata
);
    import stbs_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_lo, n_lo;
    logic [CNT_W-1:0]  r_hi, n_hi;
    logic [ADDR_W-1:0] r_mid, n_mid;
    logic              r_final, n_final;
    logic [DATA_W-1:0] r_key, n_key;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid, n_out_valid;
    t_rsp              r_rsp, n_rsp;

    logic              accept;
    logic              is_search;
    logic [CNT_W-1:0]  cnt_eff;
    logic              out_free;
    logic              hit;
    logic              less;
    logic [CNT_W-1:0]  mid_ext;
    logic [CNT_W-1:0]  p_lo, p_hi, span;
    logic [ADDR_W-1:0] p_addr;
    logic              p_final;
    logic              start;

    assign is_search = (i_in_data.req_type == REQ_SEARCH);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || (is_search && !out_free);
    assign accept    = i_in_valid && !o_in_stall;

    assign cnt_eff = (CNT_W'(i_cfg.entry_count) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                                 : CNT_W'(i_cfg.entry_count);
    assign start   = accept && is_search && (cnt_eff != '0);

    assign hit     = (i_rdata == r_key);
    assign less    = order_key(r_key, i_cfg.signed_order)
                   < order_key(i_rdata, i_cfg.signed_order);
    assign mid_ext = CNT_W'(r_mid);

    // range for the next probe: fresh on a new search, narrowed otherwise
    always_comb begin
        if (r_state == ST_IDLE) begin
            p_lo = '0;
            p_hi = cnt_eff;
        end else if (less) begin
            p_lo = r_lo;
            p_hi = mid_ext;
        end else begin
            p_lo = mid_ext;
            p_hi = r_hi;
        end
        span = p_hi - p_lo;
        if (span > CNT_W'(1)) begin
            p_addr  = ADDR_W'(p_lo + (span >> 1));
            p_final = 1'b0;
        end else begin
            p_addr  = ADDR_W'(p_lo);
            p_final = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (out_free && (hit || r_final)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_final     = r_final;
        n_key       = r_key;
        n_count     = r_count;
        n_rsp       = r_rsp;
        n_out_valid = r_out_valid && i_out_stall;
        o_ram       = '0;
        o_ram.waddr = i_in_data.entry_index[ADDR_W-1:0];
        o_ram.wdata = i_in_data.value[DATA_W-1:0];
        o_ram.raddr = p_addr;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !is_search) begin
                    o_ram.we = (CNT_W'(i_in_data.entry_index) < CNT_W'(DEPTH));
                end
                if (accept && is_search) begin
                    n_key   = i_in_data.value[DATA_W-1:0];
                    n_count = cnt_eff;
                    if (cnt_eff == '0) begin
                        // empty table answers at once
                        n_rsp.found    = 1'b0;
                        n_rsp.position = '0;
                        n_out_valid    = 1'b1;
                    end else begin
                        o_ram.re = 1'b1;
                        n_lo     = p_lo;
                        n_hi     = p_hi;
                        n_mid    = p_addr;
                        n_final  = p_final;
                    end
                end
            end
            ST_CHECK: begin
                if (hit || r_final) begin
                    if (out_free) begin
                        n_rsp.found    = hit;
                        n_rsp.position = hit ? POS_W'(r_mid) : POS_W'(r_count);
                        n_out_valid    = 1'b1;
                    end
                end else begin
                    o_ram.re = 1'b1;
                    n_lo     = p_lo;
                    n_hi     = p_hi;
                    n_mid    = p_addr;
                    n_final  = p_final;
                end
            end
            default: begin
                o_ram.re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_final <= n_final;
        r_key   <= n_key;
        r_count <= n_count;
        r_rsp   <= n_rsp;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_rsp;

endmodule
`default_nettype wire

/* rtl/sorted_table_binary_search.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Table of 1024 words, written by the user in ascending order, with entry
// writes and binary key searches over the first entry_count entries.
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_stall / i_in_data) carries write and
//   search transactions; output channel (o_out_valid / i_out_stall /
//   o_out_data) carries one result per search, none per write.
//   entry_count and signed_order are set over the APB port while idle; the
//   user must keep to this, the block does not enforce it. a write
//   is made in the cycle it is accepted and the next transaction may follow
//   at once. a search issues one table read per cycle through the single
//   read port of the table RAM: up to ceil(log2(count))+1 probes, 11 for a
//   full table; a new transaction is taken once the result is registered.
//   an empty table answers in the cycle after acceptance.
//   the output register lets writes keep flowing while a result waits; a
//   search is held off while a stalled result is pending, and a finished
//   search waits in place while the receiver stalls.
//   reset clears the registers and the control state; table contents are
//   undefined until written.
// ----------------------------------------------------------------------------
module sorted_table_binary_search (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [stbs_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [stbs_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [stbs_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire stbs_pkg::t_req                  i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output stbs_pkg::t_rsp                       o_out_data
);
    import stbs_pkg::*;

    t_cfg              cfg;
    t_ram_req          ram_req;
    logic [DATA_W-1:0] rdata;

    stbs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    stbs_search u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_ram       (ram_req),
        .i_rdata     (rdata)
    );

    stbs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

endmodule
`default_nettype wire

/* test/sorted_table_binary_search_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_tb
// Self-checking bench for the sorted table search: fills the table with
// ascending words in unsigned or signed order, mixes key searches with stray
// entry writes, and compares every result with a predicted probe sequence.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_tb;
    import stbs_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 240;
    localparam int MAX_REPORTS   = 10;

    class search_scoreboard;
        logic [DATA_W-1:0]    words [DEPTH];
        logic [CFG_CNT_W-1:0] entry_count;
        logic                 signed_order;
        t_rsp                 expected_answers [$];
        int unsigned          errors;
        int unsigned          n_writes;
        int unsigned          n_searches;
        int unsigned          n_hits;

        function new();
            entry_count  = '0;
            signed_order = 1'b0;
            errors       = 0;
            n_writes     = 0;
            n_searches   = 0;
            n_hits       = 0;
        endfunction

        function void set_register(logic idx, logic [APB_DATA_W-1:0] data);
            case (idx)
                REG_ENTRY_COUNT:  entry_count = data[CFG_CNT_W-1:0];
                REG_SIGNED_ORDER: signed_order = data[0];
                default: ;
            endcase
        endfunction

        // same probe order as the hardware; the sign flip turns signed order into unsigned
        function t_rsp lookup_key(logic [DATA_W-1:0] key);
            t_rsp              ans;
            int unsigned       cnt;
            int unsigned       lo;
            int unsigned       hi;
            int unsigned       mid;
            logic [DATA_W-1:0] flip;
            cnt = (entry_count > DEPTH) ? DEPTH : entry_count;
            ans.found = 1'b0;
            ans.position = POS_W'(cnt);
            if (cnt == 0) begin
                return ans;
            end
            flip = {signed_order, {(DATA_W-1){1'b0}}};
            lo = 0;
            hi = cnt;
            while (hi - lo > 1) begin
                mid = lo + (hi - lo) / 2;
                if (words[mid] == key) begin
                    ans.found = 1'b1;
                    ans.position = POS_W'(mid);
                    return ans;
                end
                if ((key ^ flip) < (words[mid] ^ flip)) begin
                    hi = mid;
                end else begin
                    lo = mid;
                end
            end
            if (words[lo] == key) begin
                ans.found = 1'b1;
                ans.position = POS_W'(lo);
            end
            return ans;
        endfunction

        function void note_request(t_req r);
            t_rsp ans;
            if (r.req_type == REQ_WRITE) begin
                words[r.entry_index] = r.value;
                n_writes++;
            end else begin
                ans = lookup_key(r.value);
                if (ans.found) begin
                    n_hits++;
                end
                expected_answers.push_back(ans);
                n_searches++;
            end
        endfunction

        function void report(string what, int unsigned want, int unsigned got);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
            end
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (expected_answers.size() == 0) begin
                report("result with no search pending, position", 0, got.position);
                return;
            end
            want = expected_answers.pop_front();
            if (got.found !== want.found) begin
                report("found", want.found, got.found);
            end
            if (got.position !== want.position) begin
                report("position", want.position, got.position);
            end
        endfunction

        function int unsigned pending();
            return expected_answers.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_req                  i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_rsp                  o_out_data;

    search_scoreboard sb;
    bit               tx_no_wait = 1'b0;
    bit               rx_no_wait = 1'b0;
    bit               hold_off_request = 1'b0;
    int unsigned      phases = 0;

    sorted_table_binary_search uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_data);
        end
    end

    // result side: random stall per transaction, one long hold-off on request
    initial begin
        int unsigned n;
        @(posedge i_rst_n);
        forever begin
            n = rx_no_wait ? 0 : $urandom_range(0, 15);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                n = HOLD_CYCLES;
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic write_register(logic idx, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, data);
    endtask

    // valid is left high after acceptance so back-to-back transactions need no dip
    task automatic send_item(t_req r);
        int unsigned gap;
        gap = tx_no_wait ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(r);
    endtask

    task automatic send_write(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
        t_req r;
        r.req_type    = REQ_WRITE;
        r.entry_index = idx;
        r.value       = val;
        send_item(r);
    endtask

    task automatic send_search(logic [VAL_W-1:0] key);
        t_req r;
        r.req_type    = REQ_SEARCH;
        r.entry_index = IDX_W'($urandom_range(0, DEPTH - 1));
        r.value       = key;
        send_item(r);
    endtask

    // drain all pending results, then give a trailing write time to finish
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(int unsigned count, bit order, bit refill, int unsigned items);
        int unsigned       used;
        int unsigned       sel;
        longint unsigned   stride;
        longint unsigned   fill_key;
        logic [DATA_W-1:0] k;
        phases++;
        tx_no_wait = ($urandom_range(0, 3) == 0);
        rx_no_wait = ($urandom_range(0, 3) == 0);
        write_register(REG_ENTRY_COUNT, count);
        write_register(REG_SIGNED_ORDER, APB_DATA_W'(order));
        used = (count > DEPTH) ? DEPTH : count;
        if (refill) begin
            // ascending in key space, with repeats; sign flip maps back to signed words
            stride = 64'hFFFF_FFFF / (used + 1);
            fill_key = $urandom_range(0, 32'(stride));
            if ($urandom_range(0, 3) == 0) begin
                fill_key = 0;
            end
            for (int i = 0; i < used; i++) begin
                if (i == used - 1 && $urandom_range(0, 3) == 0) begin
                    fill_key = 64'hFFFF_FFFF;
                end
                send_write(IDX_W'(i), VAL_W'(fill_key) ^ {order, {(VAL_W-1){1'b0}}});
                if ($urandom_range(0, 3) != 0) begin
                    fill_key += $urandom_range(1, 32'(stride));
                end
            end
        end
        repeat (items) begin
            if ($urandom_range(0, 11) == 0) begin
                send_write(IDX_W'($urandom_range(0, DEPTH - 1)), $urandom());
            end else begin
                sel = $urandom_range(0, 9);
                if (used == 0 && sel <= 6) begin
                    sel = 7;
                end
                case (sel)
                    0, 1, 2, 3, 4, 5: k = sb.words[$urandom_range(0, used - 1)];
                    6: begin
                        k = sb.words[$urandom_range(0, used - 1)];
                        k = $urandom_range(0, 1) ? k + 1'b1 : k - 1'b1;
                    end
                    7, 8: k = $urandom();
                    default: begin
                        case ($urandom_range(0, 3))
                            0: k = '0;
                            1: k = '1;
                            2: k = {1'b1, {(DATA_W-1){1'b0}}};
                            default: k = {1'b0, {(DATA_W-1){1'b1}}};
                        endcase
                    end
                endcase
                send_search(k);
            end
        end
        settle();
    endtask

    initial begin
        bit failed;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table straight out of reset
        send_search('0);
        send_search('1);
        settle();

        // three entries at the unsigned extremes, plus the top index
        write_register(REG_ENTRY_COUNT, 3);
        send_write(0, 32'h0000_0000);
        send_write(1, 32'h8000_0000);
        send_write(2, 32'hFFFF_FFFF);
        send_write(IDX_W'(DEPTH - 1), 32'h5A5A_A5A5);
        send_search(32'h0000_0000);
        send_search(32'h8000_0000);
        send_search(32'hFFFF_FFFF);
        send_search(32'h7FFF_FFFF);
        send_search(32'h0000_0001);
        settle();

        // signed order across the sign boundary
        write_register(REG_SIGNED_ORDER, 1);
        write_register(REG_ENTRY_COUNT, 4);
        send_write(0, 32'h8000_0000);
        send_write(1, 32'hFFFF_FFFF);
        send_write(2, 32'h0000_0000);
        send_write(3, 32'h7FFF_FFFF);
        send_search(32'h8000_0000);
        send_search(32'hFFFF_FFFF);
        send_search(32'h7FFF_FFFF);
        send_search(32'h0000_0001);

        // out-of-order entry, probes still follow the fixed sequence
        send_write(1, 32'h7FFF_FFFF);
        send_search(32'hFFFF_FFFF);
        settle();

        for (int p = 0; p < 8; p++) begin
            if (p == 2) begin
                hold_off_request = 1'b1;
            end
            if (p == 0) begin
                run_phase(0, 1'b0, 1'b1, 45);
            end else if (p == 1) begin
                run_phase(1, 1'b1, 1'b1, 45);
            end else if ($urandom_range(0, 3) == 0) begin
                run_phase($urandom_range(2, 4), bit'($urandom_range(0, 1)), 1'b1, 45);
            end else begin
                run_phase($urandom_range(5, 48), bit'($urandom_range(0, 1)), 1'b1, 45);
            end
        end

        // full table, then a count beyond the depth over the same contents
        hold_off_request = 1'b1;
        run_phase(DEPTH, bit'($urandom_range(0, 1)), 1'b1, 120);
        run_phase(2047, sb.signed_order, 1'b0, 120);

        failed = (sb.errors != 0) || (sb.pending() != 0);
        $display("covered %0d table writes and %0d searches (%0d hits) in %0d config phases,",
                 sb.n_writes, sb.n_searches, sb.n_hits, phases);
        $display("entry counts from empty to beyond the depth, unsigned and signed order");
        if (!failed) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/stbs_pkg.sv
rtl/stbs_ram.sv
rtl/stbs_regs.sv
rtl/stbs_search.sv
rtl/sorted_table_binary_search.sv
test/sorted_table_binary_search_tb.sv
